// ===== rtl/plob_pkg.sv =====
// Shared constants, codes and controller/datapath signal bundles for the
// price level order book. No dependencies.
`default_nettype none

package plob_pkg;

   localparam int unsigned PRICE_LEVELS = 4096;
   localparam int unsigned PRICE_W      = 12;
   localparam int unsigned KIND_W       = 2;
   localparam int unsigned AMOUNT_W     = 24;
   localparam int unsigned POS_W        = 20;
   localparam int unsigned COST_W       = 36;
   localparam int unsigned ORD_W        = 16;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned MUL_W        = 32;
   localparam int unsigned DIV_SHIFT    = 20;

   localparam int unsigned DEF_BUCKET_FANOUT = 16;
   localparam int unsigned DEF_LEVEL_DEPTH   = 256;

   localparam logic [ORD_W-1:0] ORD_MAX = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_EXHAUST = 2'd3;

   typedef struct packed {
      logic clr;
      logic take;
      logic disp;
      logic add1;
      logic add2;
      logic add3;
      logic add4;
      logic crd;
      logic ccmp;
      logic mrd;
      logic mcmp;
      logic lrd;
      logic lcmp;
      logic cnrd;
      logic cnwr;
      logic cnupd;
      logic exrd;
      logic excalc;
      logic fin;
   } plob_cmd_type;

   typedef struct packed {
      logic              clr_last;
      logic [KIND_W-1:0] kind;
      logic              lvl_full;
      logic              pos_oob;
      logic              amt_zero;
      logic              tot_zero;
      logic              c_hit;
      logic              m_hit;
      logic              l_hit;
      logic              cn_more;
      logic              ex_keep;
      logic              ex_rem_zero;
      logic              tot_one;
      logic              n_one;
      logic              midv_one;
      logic              crsv_one;
      logic              out_busy;
   } plob_stat_type;

   function automatic int unsigned width_of(input int unsigned n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/plob_if.sv =====
// Valid/ready channel interfaces for order book requests and responses.
// Depends on plob_pkg for field widths.
`default_nettype none

interface plob_req_if import plob_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [PRICE_W-1:0]  price;
   logic [AMOUNT_W-1:0] amount;
   logic [POS_W-1:0]    position;

   modport source(output valid, kind, price, amount, position, input ready);
   modport sink(input valid, kind, price, amount, position, output ready);
endinterface

interface plob_rsp_if import plob_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COST_W-1:0]   cost;
   logic [AMOUNT_W-1:0] unfilled;
   logic [STATUS_W-1:0] status;

   modport source(output valid, cost, unfilled, status, input ready);
   modport sink(input valid, cost, unfilled, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/price_level_order_book.sv =====
// One-sided price-time priority order book over 4096 price levels.
// Requests arrive on req_ch (kind, price, amount, position); one response per
// request leaves on rsp_ch (cost, unfilled, status). A transfer happens at a
// rising clock edge where valid and ready are both high.
// After reset the block runs a clearing pass over the level table and the
// bucket counts, with req_ch.ready low, then takes requests.
// One request is worked on at a time. A cancel reads the coarse, mid and
// level counts in turn while walking to the order's rank, then shifts each
// order behind it in its level one place forward. An execute reads the
// counts while skipping empty buckets and levels, then fills against the
// orders of the level from its head one by one. The count and order
// memories have registered reads. A finished response sits in an output
// register; the block takes the next request while it waits, and holds the
// following result until the receiver takes the first. A full level or a
// rank past the book is reported in status without changing the book; an
// execute that runs the book empty reports the rest of its amount in
// unfilled.
// Depends on plob_pkg, plob_if, plob_ctrl and plob_dp.
`default_nettype none

module price_level_order_book import plob_pkg::*; #(
   parameter int unsigned BUCKET_FANOUT = DEF_BUCKET_FANOUT,
   parameter int unsigned LEVEL_DEPTH   = DEF_LEVEL_DEPTH
) (
   input logic         clock,
   input logic         reset,
   plob_req_if.sink    req_ch,
   plob_rsp_if.source  rsp_ch
);

   plob_cmd_type  cmd;
   plob_stat_type stat;

   plob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   plob_dp #(
      .BUCKET_FANOUT (BUCKET_FANOUT),
      .LEVEL_DEPTH   (LEVEL_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_ch.kind),
      .req_price    (req_ch.price),
      .req_amount   (req_ch.amount),
      .req_position (req_ch.position),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_cost     (rsp_ch.cost),
      .rsp_unfilled (rsp_ch.unfilled),
      .rsp_status   (rsp_ch.status)
   );

endmodule

`default_nettype wire

// ===== rtl/plob_ctrl.sv =====
// Sequencing state machine of the order book: clearing pass, add, cancel
// search and shift, execute walk. Depends on plob_pkg.
`default_nettype none

module plob_ctrl import plob_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output plob_cmd_type  cmd,
   input  plob_stat_type stat
);

   localparam logic [4:0] S_CLR    = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_DISP   = 5'd2;
   localparam logic [4:0] S_ADD1   = 5'd3;
   localparam logic [4:0] S_ADD2   = 5'd4;
   localparam logic [4:0] S_ADD3   = 5'd5;
   localparam logic [4:0] S_ADD4   = 5'd6;
   localparam logic [4:0] S_CRD    = 5'd7;
   localparam logic [4:0] S_CCMP   = 5'd8;
   localparam logic [4:0] S_MRD    = 5'd9;
   localparam logic [4:0] S_MCMP   = 5'd10;
   localparam logic [4:0] S_LRD    = 5'd11;
   localparam logic [4:0] S_LCMP   = 5'd12;
   localparam logic [4:0] S_CNRD   = 5'd13;
   localparam logic [4:0] S_CNWR   = 5'd14;
   localparam logic [4:0] S_CNUPD  = 5'd15;
   localparam logic [4:0] S_EXRD   = 5'd16;
   localparam logic [4:0] S_EXCALC = 5'd17;
   localparam logic [4:0] S_FIN    = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DISP;
         end
         S_DISP: begin
            case (stat.kind)
               KIND_ADD: state_in = S_ADD1;
               KIND_CANCEL: begin
                  state_in = stat.pos_oob ? S_FIN : S_CRD;
               end
               KIND_EXEC: begin
                  state_in = (stat.amt_zero || stat.tot_zero) ? S_FIN : S_CRD;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_ADD1: state_in = S_ADD2;
         S_ADD2: begin
            state_in = stat.lvl_full ? S_FIN : S_ADD3;
         end
         S_ADD3: state_in = S_ADD4;
         S_ADD4: state_in = S_FIN;
         S_CRD: state_in = S_CCMP;
         S_CCMP: begin
            state_in = stat.c_hit ? S_MRD : S_CRD;
         end
         S_MRD: state_in = S_MCMP;
         S_MCMP: begin
            state_in = stat.m_hit ? S_LRD : S_MRD;
         end
         S_LRD: state_in = S_LCMP;
         S_LCMP: begin
            if (!stat.l_hit) begin
               state_in = S_LRD;
            end else if (stat.kind == KIND_CANCEL) begin
               state_in = S_CNRD;
            end else begin
               state_in = S_EXRD;
            end
         end
         S_CNRD: begin
            state_in = stat.cn_more ? S_CNWR : S_CNUPD;
         end
         S_CNWR: state_in = S_CNRD;
         S_CNUPD: state_in = S_FIN;
         S_EXRD: state_in = S_EXCALC;
         S_EXCALC: begin
            if (stat.ex_keep || stat.ex_rem_zero || stat.tot_one) begin
               state_in = S_FIN;
            end else if (!stat.n_one) begin
               state_in = S_EXRD;
            end else if (!stat.midv_one) begin
               state_in = S_LRD;
            end else if (!stat.crsv_one) begin
               state_in = S_MRD;
            end else begin
               state_in = S_CRD;
            end
         end
         S_FIN: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.clr    = (state_ff == S_CLR);
      cmd.take   = (state_ff == S_IDLE) && req_valid;
      cmd.disp   = (state_ff == S_DISP);
      cmd.add1   = (state_ff == S_ADD1);
      cmd.add2   = (state_ff == S_ADD2);
      cmd.add3   = (state_ff == S_ADD3);
      cmd.add4   = (state_ff == S_ADD4);
      cmd.crd    = (state_ff == S_CRD);
      cmd.ccmp   = (state_ff == S_CCMP);
      cmd.mrd    = (state_ff == S_MRD);
      cmd.mcmp   = (state_ff == S_MCMP);
      cmd.lrd    = (state_ff == S_LRD);
      cmd.lcmp   = (state_ff == S_LCMP);
      cmd.cnrd   = (state_ff == S_CNRD);
      cmd.cnwr   = (state_ff == S_CNWR);
      cmd.cnupd  = (state_ff == S_CNUPD);
      cmd.exrd   = (state_ff == S_EXRD);
      cmd.excalc = (state_ff == S_EXCALC);
      cmd.fin    = (state_ff == S_FIN) && !stat.out_busy;
   end

endmodule

`default_nettype wire

// ===== rtl/plob_dp.sv =====
// Datapath of the order book: level, bucket and order memories, search
// registers, fill arithmetic and the response register. Depends on plob_pkg.
`default_nettype none

module plob_dp import plob_pkg::*; #(
   parameter int unsigned BUCKET_FANOUT = DEF_BUCKET_FANOUT,
   parameter int unsigned LEVEL_DEPTH   = DEF_LEVEL_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  plob_cmd_type        cmd,
   output plob_stat_type       stat,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [PRICE_W-1:0]  req_price,
   input  logic [AMOUNT_W-1:0] req_amount,
   input  logic [POS_W-1:0]    req_position,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [COST_W-1:0]   rsp_cost,
   output logic [AMOUNT_W-1:0] rsp_unfilled,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int unsigned FAN      = BUCKET_FANOUT;
   localparam int unsigned LD       = LEVEL_DEPTH;
   localparam int unsigned MID_B    = (PRICE_LEVELS + FAN - 1) / FAN;
   localparam int unsigned CRS_SPAN = FAN * FAN;
   localparam int unsigned CRS_B    = (PRICE_LEVELS + CRS_SPAN - 1) / CRS_SPAN;
   localparam int unsigned HW       = $clog2(LD);
   localparam int unsigned NW       = $clog2(LD + 1);
   localparam int unsigned MW       = width_of(MID_B);
   localparam int unsigned CBW      = width_of(CRS_B);
   localparam int unsigned MCW      = $clog2(FAN * LD + 1);
   localparam int unsigned CCW      = $clog2(CRS_SPAN * LD + 1);
   localparam int unsigned TW       = $clog2(PRICE_LEVELS * LD + 1);
   localparam int unsigned CMPW     = (TW > POS_W) ? TW : POS_W;
   localparam int unsigned OAW      = PRICE_W + HW;
   localparam int unsigned LW       = 2 * HW + NW;
   localparam int unsigned PRODW    = ORD_W + PRICE_W;
   localparam int unsigned RECIP    = ((1 << DIV_SHIFT) + FAN - 1) / FAN;

   logic [LW-1:0]    lvl_mem [PRICE_LEVELS];
   logic [MCW-1:0]   mid_mem [MID_B];
   logic [CCW-1:0]   crs_mem [CRS_B];
   logic [ORD_W-1:0] ord_mem [2**OAW];

   logic [LW-1:0]    lvl_rd_ff;
   logic [MCW-1:0]   mid_rd_ff;
   logic [CCW-1:0]   crs_rd_ff;
   logic [ORD_W-1:0] ord_rd_ff;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CBW-1:0]      c_ff, c_in;
   logic [MW-1:0]       cm_ff, cm_in;
   logic [PRICE_W-1:0]  cp_ff, cp_in;
   logic [MW-1:0]       m_ff, m_in;
   logic [PRICE_W-1:0]  mp_ff, mp_in;
   logic [PRICE_W-1:0]  p_ff, p_in;
   logic [MW-1:0]       midx_ff, midx_in;
   logic [CBW-1:0]      cidx_ff, cidx_in;
   logic [HW-1:0]       h_ff, h_in;
   logic [HW-1:0]       t_ff, t_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       k_ff, k_in;
   logic [MCW-1:0]      midv_ff, midv_in;
   logic [CCW-1:0]      crsv_ff, crsv_in;
   logic [TW-1:0]       tot_ff, tot_in;
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic [AMOUNT_W-1:0] rem_ff, rem_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [PRICE_W-1:0]  clr_ff, clr_in;
   logic                ov_ff, ov_in;
   logic [COST_W-1:0]   ocost_ff, ocost_in;
   logic [AMOUNT_W-1:0] ounf_ff, ounf_in;
   logic [STATUS_W-1:0] ost_ff, ost_in;

   logic               lvl_we, mid_we, crs_we, ord_we;
   logic [PRICE_W-1:0] lvl_wa, lvl_ra;
   logic [LW-1:0]      lvl_wd;
   logic [MW-1:0]      mid_wa, mid_ra;
   logic [MCW-1:0]     mid_wd;
   logic [CBW-1:0]     crs_wa, crs_ra;
   logic [CCW-1:0]     crs_wd;
   logic [OAW-1:0]     ord_wa, ord_ra;
   logic [ORD_W-1:0]   ord_wd;

   logic [HW-1:0]      lvl_h, lvl_t;
   logic [NW-1:0]      lvl_n;
   logic [MUL_W-1:0]   mul_mid, mul_crs;
   logic [ORD_W-1:0]   add_amt;
   logic               ex_lt, ex_pop;
   logic [ORD_W-1:0]   ex_mn, ex_xr;
   logic [AMOUNT_W-1:0] ex_rem;
   logic [PRODW-1:0]   ex_prod;
   logic [HW-1:0]      h_next, t_prev;

   function automatic logic [HW-1:0] ring(input logic [HW-1:0] b, input logic [NW-1:0] k);
      logic [NW:0] s;
      s = (NW+1)'(b) + (NW+1)'(k);
      if (s >= (NW+1)'(LD)) s = s - (NW+1)'(LD);
      return s[HW-1:0];
   endfunction

   assign lvl_h = lvl_rd_ff[LW-1 -: HW];
   assign lvl_t = lvl_rd_ff[NW +: HW];
   assign lvl_n = lvl_rd_ff[NW-1:0];

   assign mul_mid = MUL_W'(price_ff) * MUL_W'(RECIP);
   assign mul_crs = MUL_W'(midx_ff) * MUL_W'(RECIP);
   assign add_amt = (amt_ff > AMOUNT_W'(ORD_MAX)) ? ORD_MAX : amt_ff[ORD_W-1:0];

   assign ex_lt   = AMOUNT_W'(ord_rd_ff) < rem_ff;
   assign ex_mn   = ex_lt ? ord_rd_ff : rem_ff[ORD_W-1:0];
   assign ex_xr   = ord_rd_ff - ex_mn;
   assign ex_rem  = rem_ff - AMOUNT_W'(ex_mn);
   assign ex_prod = PRODW'(ex_mn) * PRODW'(p_ff);
   assign ex_pop  = (ex_xr == '0);
   assign h_next  = ring(h_ff, NW'(1));
   assign t_prev  = (t_ff == '0) ? HW'(LD - 1) : (t_ff - HW'(1));

   always_comb begin
      stat             = '0;
      stat.clr_last    = (clr_ff == '1);
      stat.kind        = kind_ff;
      stat.lvl_full    = (lvl_n >= NW'(LD));
      stat.pos_oob     = (CMPW'(pos_ff) >= CMPW'(tot_ff));
      stat.amt_zero    = (amt_ff == '0);
      stat.tot_zero    = (tot_ff == '0);
      stat.c_hit       = (CMPW'(pos_ff) < CMPW'(crs_rd_ff));
      stat.m_hit       = (CMPW'(pos_ff) < CMPW'(mid_rd_ff));
      stat.l_hit       = (CMPW'(pos_ff) < CMPW'(lvl_n));
      stat.cn_more     = ((NW+1)'(k_ff) + (NW+1)'(1)) < (NW+1)'(n_ff);
      stat.ex_keep     = !ex_pop;
      stat.ex_rem_zero = (ex_rem == '0);
      stat.tot_one     = (tot_ff == TW'(1));
      stat.n_one       = (n_ff == NW'(1));
      stat.midv_one    = (midv_ff == MCW'(1));
      stat.crsv_one    = (crsv_ff == CCW'(1));
      stat.out_busy    = ov_ff && !rsp_ready;
   end

   always_comb begin
      lvl_ra = cmd.add1 ? price_ff : p_ff;
      mid_ra = cmd.add2 ? midx_ff : m_ff;
      crs_ra = cmd.add3 ? cidx_ff : c_ff;
      ord_ra = cmd.cnrd ? {p_ff, ring(h_ff, k_ff + NW'(1))} : {p_ff, h_ff};

      lvl_we = 1'b0;
      lvl_wa = p_ff;
      lvl_wd = '0;
      mid_we = 1'b0;
      mid_wa = m_ff;
      mid_wd = '0;
      crs_we = 1'b0;
      crs_wa = c_ff;
      crs_wd = '0;
      ord_we = 1'b0;
      ord_wa = {p_ff, h_ff};
      ord_wd = ex_xr;

      if (cmd.clr) begin
         lvl_we = 1'b1;
         lvl_wa = clr_ff;
         mid_we = ((PRICE_W+1)'(clr_ff) < (PRICE_W+1)'(MID_B));
         mid_wa = MW'(clr_ff);
         crs_we = ((PRICE_W+1)'(clr_ff) < (PRICE_W+1)'(CRS_B));
         crs_wa = CBW'(clr_ff);
      end
      if (cmd.add3) begin
         lvl_we = 1'b1;
         lvl_wa = price_ff;
         lvl_wd = {h_ff, ring(t_ff, NW'(1)), n_ff + NW'(1)};
         mid_we = 1'b1;
         mid_wa = midx_ff;
         mid_wd = mid_rd_ff + MCW'(1);
         ord_we = 1'b1;
         ord_wa = {price_ff, t_ff};
         ord_wd = add_amt;
      end
      if (cmd.add4) begin
         crs_we = 1'b1;
         crs_wa = cidx_ff;
         crs_wd = crs_rd_ff + CCW'(1);
      end
      if (cmd.cnwr) begin
         ord_we = 1'b1;
         ord_wa = {p_ff, ring(h_ff, k_ff)};
         ord_wd = ord_rd_ff;
      end
      if (cmd.cnupd) begin
         lvl_we = 1'b1;
         lvl_wd = {h_ff, t_prev, n_ff - NW'(1)};
         mid_we = 1'b1;
         mid_wd = midv_ff - MCW'(1);
         crs_we = 1'b1;
         crs_wd = crsv_ff - CCW'(1);
      end
      if (cmd.excalc) begin
         if (ex_pop) begin
            lvl_we = 1'b1;
            lvl_wd = {h_next, t_ff, n_ff - NW'(1)};
            mid_we = 1'b1;
            mid_wd = midv_ff - MCW'(1);
            crs_we = 1'b1;
            crs_wd = crsv_ff - CCW'(1);
         end else begin
            ord_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
      lvl_rd_ff <= lvl_mem[lvl_ra];
   end

   always_ff @(posedge clock) begin
      if (mid_we) mid_mem[mid_wa] <= mid_wd;
      mid_rd_ff <= mid_mem[mid_ra];
   end

   always_ff @(posedge clock) begin
      if (crs_we) crs_mem[crs_wa] <= crs_wd;
      crs_rd_ff <= crs_mem[crs_ra];
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_wa] <= ord_wd;
      ord_rd_ff <= ord_mem[ord_ra];
   end

   always_comb begin
      kind_in  = kind_ff;
      price_in = price_ff;
      amt_in   = amt_ff;
      pos_in   = pos_ff;
      c_in     = c_ff;
      cm_in    = cm_ff;
      cp_in    = cp_ff;
      m_in     = m_ff;
      mp_in    = mp_ff;
      p_in     = p_ff;
      midx_in  = midx_ff;
      cidx_in  = cidx_ff;
      h_in     = h_ff;
      t_in     = t_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      midv_in  = midv_ff;
      crsv_in  = crsv_ff;
      tot_in   = tot_ff;
      cost_in  = cost_ff;
      rem_in   = rem_ff;
      st_in    = st_ff;
      clr_in   = clr_ff;
      ov_in    = ov_ff;
      ocost_in = ocost_ff;
      ounf_in  = ounf_ff;
      ost_in   = ost_ff;

      if (cmd.clr) clr_in = clr_ff + PRICE_W'(1);

      if (cmd.take) begin
         kind_in  = req_kind;
         price_in = req_price;
         amt_in   = req_amount;
         pos_in   = req_position;
      end

      if (cmd.disp) begin
         c_in    = '0;
         cm_in   = '0;
         cp_in   = '0;
         cost_in = '0;
         rem_in  = (kind_ff == KIND_EXEC) ? amt_ff : '0;
         st_in   = STAT_OK;
         if (kind_ff == KIND_EXEC) begin
            pos_in = '0;
            if (amt_ff != '0 && tot_ff == '0) st_in = STAT_EXHAUST;
         end
         if (kind_ff == KIND_CANCEL && stat.pos_oob) st_in = STAT_RANGE;
      end

      if (cmd.add1) midx_in = MW'(mul_mid >> DIV_SHIFT);
      if (cmd.add2) begin
         cidx_in = CBW'(mul_crs >> DIV_SHIFT);
         h_in    = lvl_h;
         t_in    = lvl_t;
         n_in    = lvl_n;
         if (stat.lvl_full) st_in = STAT_FULL;
      end
      if (cmd.add4) tot_in = tot_ff + TW'(1);

      if (cmd.ccmp) begin
         if (stat.c_hit) begin
            crsv_in = crs_rd_ff;
            m_in    = cm_ff;
            mp_in   = cp_ff;
         end else begin
            pos_in = pos_ff - POS_W'(crs_rd_ff);
            c_in   = c_ff + CBW'(1);
            cm_in  = cm_ff + MW'(FAN);
            cp_in  = cp_ff + PRICE_W'(CRS_SPAN);
         end
      end

      if (cmd.mcmp) begin
         if (stat.m_hit) begin
            midv_in = mid_rd_ff;
            p_in    = mp_ff;
         end else begin
            pos_in = pos_ff - POS_W'(mid_rd_ff);
            m_in   = m_ff + MW'(1);
            mp_in  = mp_ff + PRICE_W'(FAN);
         end
      end

      if (cmd.lcmp) begin
         if (stat.l_hit) begin
            h_in = lvl_h;
            t_in = lvl_t;
            n_in = lvl_n;
            k_in = NW'(pos_ff);
         end else begin
            pos_in = pos_ff - POS_W'(lvl_n);
            p_in   = p_ff + PRICE_W'(1);
         end
      end

      if (cmd.cnwr) k_in = k_ff + NW'(1);

      if (cmd.cnupd) begin
         t_in   = t_prev;
         n_in   = n_ff - NW'(1);
         tot_in = tot_ff - TW'(1);
      end

      if (cmd.excalc) begin
         cost_in = cost_ff + COST_W'(ex_prod);
         rem_in  = ex_rem;
         st_in   = STAT_OK;
         if (ex_pop) begin
            h_in    = h_next;
            n_in    = n_ff - NW'(1);
            midv_in = midv_ff - MCW'(1);
            crsv_in = crsv_ff - CCW'(1);
            tot_in  = tot_ff - TW'(1);
            if (ex_rem != '0) begin
               if (stat.tot_one) begin
                  st_in = STAT_EXHAUST;
               end else if (stat.n_one) begin
                  if (!stat.midv_one) begin
                     p_in = p_ff + PRICE_W'(1);
                  end else if (!stat.crsv_one) begin
                     m_in  = m_ff + MW'(1);
                     mp_in = mp_ff + PRICE_W'(FAN);
                  end else begin
                     c_in  = c_ff + CBW'(1);
                     cm_in = cm_ff + MW'(FAN);
                     cp_in = cp_ff + PRICE_W'(CRS_SPAN);
                  end
               end
            end
         end
      end

      if (cmd.fin) begin
         ov_in    = 1'b1;
         ocost_in = cost_ff;
         ounf_in  = rem_ff;
         ost_in   = st_ff;
      end else if (rsp_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         tot_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         tot_ff <= tot_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      price_ff <= price_in;
      amt_ff   <= amt_in;
      pos_ff   <= pos_in;
      c_ff     <= c_in;
      cm_ff    <= cm_in;
      cp_ff    <= cp_in;
      m_ff     <= m_in;
      mp_ff    <= mp_in;
      p_ff     <= p_in;
      midx_ff  <= midx_in;
      cidx_ff  <= cidx_in;
      h_ff     <= h_in;
      t_ff     <= t_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      midv_ff  <= midv_in;
      crsv_ff  <= crsv_in;
      cost_ff  <= cost_in;
      rem_ff   <= rem_in;
      st_ff    <= st_in;
      ocost_ff <= ocost_in;
      ounf_ff  <= ounf_in;
      ost_ff   <= ost_in;
   end

   assign rsp_valid    = ov_ff;
   assign rsp_cost     = ocost_ff;
   assign rsp_unfilled = ounf_ff;
   assign rsp_status   = ost_ff;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for price_level_order_book: random and directed orders,
// with a scoreboard that tracks the book in price-time order and checks each response.
// Depends on plob_pkg, plob_if and the block under test.

module testbench;
   import plob_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned BOOK_DEPTH = DEF_LEVEL_DEPTH;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned RANDOM_ITEMS = 680;

   typedef struct packed {
      logic [COST_W-1:0]   cost;
      logic [AMOUNT_W-1:0] unfilled;
      logic [STATUS_W-1:0] status;
   } fill_report_type;

   class book_scoreboard;
      bit [ORD_W-1:0] levels[PRICE_LEVELS][$];
      int unsigned resting;
      fill_report_type expected_fills[$];
      int unsigned mismatches;

      function void note_request(logic [KIND_W-1:0] kind, logic [PRICE_W-1:0] price,
                                 logic [AMOUNT_W-1:0] amount, logic [POS_W-1:0] position);
         fill_report_type r;
         int unsigned rank;
         int unsigned rem;
         int unsigned front;
         int unsigned fill;
         longint unsigned total;
         r = '0;
         case (kind)
            KIND_ADD: begin
               if (levels[price].size() >= BOOK_DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  levels[price].push_back((amount > ORD_MAX) ? ORD_MAX : amount[ORD_W-1:0]);
                  resting++;
               end
            end
            KIND_CANCEL: begin
               rank = 32'(position);
               if (rank >= resting) begin
                  r.status = STAT_RANGE;
               end else begin
                  for (int p = 0; p < PRICE_LEVELS; p++) begin
                     if (rank < levels[p].size()) begin
                        levels[p].delete(rank);
                        resting--;
                        break;
                     end
                     rank -= levels[p].size();
                  end
               end
            end
            KIND_EXEC: begin
               rem = 32'(amount);
               total = 0;
               for (int p = 0; p < PRICE_LEVELS && rem > 0; p++) begin
                  while (levels[p].size() > 0 && rem > 0) begin
                     front = 32'(levels[p][0]);
                     fill = (front < rem) ? front : rem;
                     front -= fill;
                     rem -= fill;
                     total += longint'(fill) * p;
                     if (front == 0) begin
                        void'(levels[p].pop_front());
                        resting--;
                     end else begin
                        levels[p][0] = ORD_W'(front);
                     end
                  end
               end
               r.cost = total[COST_W-1:0];
               r.unfilled = rem[AMOUNT_W-1:0];
               r.status = (rem > 0) ? STAT_EXHAUST : STAT_OK;
            end
            default: ;
         endcase
         expected_fills.push_back(r);
      endfunction

      function void check_response(fill_report_type got);
         fill_report_type want;
         if (expected_fills.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response with nothing outstanding: cost %0d unfilled %0d status %0d",
                        got.cost, got.unfilled, got.status);
            return;
         end
         want = expected_fills.pop_front();
         if (got.cost !== want.cost || got.unfilled !== want.unfilled ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected cost %0d unfilled %0d status %0d, got %0d %0d %0d",
                        want.cost, want.unfilled, want.status,
                        got.cost, got.unfilled, got.status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned cycle_count = 0;
   book_scoreboard book;

   plob_req_if req_ch ();
   plob_rsp_if rsp_ch ();

   price_level_order_book dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         book.check_response({rsp_ch.cost, rsp_ch.unfilled, rsp_ch.status});
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_request(logic [KIND_W-1:0] kind, logic [PRICE_W-1:0] price,
                               logic [AMOUNT_W-1:0] amount, logic [POS_W-1:0] position);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.price <= price;
      req_ch.amount <= amount;
      req_ch.position <= position;
      do @(posedge clock); while (!req_ch.ready);
      book.note_request(kind, price, amount, position);
   endtask

   task automatic send_random_request();
      int unsigned sel;
      logic [KIND_W-1:0] kind;
      logic [PRICE_W-1:0] price;
      logic [AMOUNT_W-1:0] amount;
      logic [POS_W-1:0] position;
      sel = $urandom_range(99);
      if (sel < ((book.resting < 200) ? 45 : 20)) kind = KIND_ADD;
      else if (sel < 65) kind = KIND_CANCEL;
      else if (sel < 95) kind = KIND_EXEC;
      else kind = KIND_UNUSED;
      sel = $urandom_range(99);
      if (sel < 60) price = PRICE_W'(1000 + $urandom_range(31));
      else if (sel < 85) price = PRICE_W'($urandom_range(4095));
      else price = PRICE_W'($urandom_range(15));
      sel = $urandom_range(99);
      if (kind == KIND_EXEC) begin
         if (sel < 70) amount = AMOUNT_W'($urandom_range(1500, 1));
         else if (sel < 85) amount = AMOUNT_W'($urandom_range(20));
         else if (sel < 95) amount = AMOUNT_W'($urandom);
         else amount = '0;
      end else begin
         if (sel < 70) amount = AMOUNT_W'($urandom_range(500, 1));
         else if (sel < 80) amount = '0;
         else if (sel < 90) amount = AMOUNT_W'($urandom_range(65535));
         else amount = AMOUNT_W'($urandom);
      end
      sel = $urandom_range(99);
      if (sel < 75 && book.resting > 0) position = POS_W'($urandom_range(book.resting - 1));
      else if (sel < 90) position = POS_W'(book.resting + $urandom_range(3));
      else position = POS_W'($urandom);
      send_request(kind, price, amount, position);
   endtask

   task automatic wait_drained();
      while (book.expected_fills.size() != 0) @(posedge clock);
   endtask

   initial begin
      book = new();
      sender_idle_pct = 37;
      receiver_stall_pct = 56;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_ADD;
      req_ch.price = '0;
      req_ch.amount = '0;
      req_ch.position = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_EXEC, '0, 24'd10, '0);
      send_request(KIND_CANCEL, '0, '0, '0);
      send_request(KIND_ADD, 12'd0, 24'd0, '0);
      send_request(KIND_ADD, 12'd4095, 24'hFFFFFF, '0);
      send_request(KIND_ADD, 12'd0, 24'd65535, '0);
      send_request(KIND_ADD, 12'd100, 24'd1, '0);
      send_request(KIND_ADD, 12'd100, 24'd7, '0);
      send_request(KIND_CANCEL, '0, '0, 20'hFFFFF);
      send_request(KIND_CANCEL, '0, '0, 20'd4);
      send_request(KIND_CANCEL, '0, '0, 20'd3);
      send_request(KIND_EXEC, '0, 24'd0, '0);
      send_request(KIND_EXEC, '0, 24'd1, '0);
      send_request(KIND_UNUSED, 12'hFFF, 24'hFFFFFF, 20'hFFFFF);
      send_request(KIND_CANCEL, '0, '0, 20'd0);
      for (int i = 0; i <= BOOK_DEPTH; i++)
         send_request(KIND_ADD, 12'd4095, 24'(i % 3), '0);
      send_request(KIND_CANCEL, '0, '0, 20'(book.resting - 1));
      send_request(KIND_CANCEL, '0, '0, 20'd2);
      send_request(KIND_EXEC, '0, 24'd70000, '0);
      send_request(KIND_EXEC, '0, 24'hFFFFFF, '0);
      send_request(KIND_EXEC, '0, 24'd5, '0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            sender_idle_pct = 56;
            receiver_stall_pct = 37;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         send_random_request();
      end
      req_ch.valid <= 1'b0;

      wait_drained();
      repeat (1000) @(posedge clock);
      if (book.mismatches == 0 && book.expected_fills.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/plob_pkg.sv
rtl/plob_if.sv
rtl/plob_ctrl.sv
rtl/plob_dp.sv
rtl/price_level_order_book.sv
dv/testbench.sv
